// ----- src/lsf_pkg.sv -----
// Shared types, constants and channel arithmetic for the LED strip framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsf_pkg;

  // command codes on the input channel
  typedef enum logic [1:0] {
    ActBegin = 2'd0,
    ActPixel = 2'd1,
    ActEnd   = 2'd2
  } act_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CfgBrightness  = 1'b0,
    CfgStripLength = 1'b1
  } cfg_idx_t;

  localparam int MaxLeds     = 1023;
  localparam int LenW        = $clog2(MaxLeds + 1);
  localparam int ResultLimit = 64;
  localparam int CountW      = $clog2(ResultLimit + 1);
  localparam int FrameBytes  = 4;

  localparam logic [7:0] BrightnessReset = 8'd64;
  localparam logic [9:0] StripLengthReset = 10'd0;
  localparam logic [7:0] FillByte = 8'hFF;

  // one job for the serializer: bytes go out msb first, count may be zero
  typedef struct packed {
    logic [31:0]       frame;
    logic [CountW-1:0] count;
  } job_t;

  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] c);
    widen6 = {c, c[5:4]};
  endfunction

  // floor(c * b / 255), exact over the whole 8x8 product range
  function automatic logic [7:0] scale(input logic [7:0] c, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * b;
    sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
    scale = sum[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- src/lsf_encode.sv -----
// Builds the byte job for one registered command: start frame, LED frame or end frame.
// Depends on lsf_pkg.
`default_nettype none

module lsf_encode
  import lsf_pkg::*;
(
  input  logic [1:0] action,
  input  logic [15:0] pixel_value,
  input  logic [7:0] brightness,
  input  logic [9:0] strip_length,
  output job_t       job
);

  logic [LenW-1:0] len;
  logic [LenW:0]   len_round;
  logic [LenW-4:0] end_count;
  logic [7:0]      red;
  logic [7:0]      green;
  logic [7:0]      blue;

  always_comb begin
    len = LenW'(strip_length);
    if (len > LenW'(MaxLeds)) begin
      len = LenW'(MaxLeds);
    end
    len_round = {1'b0, len} + (LenW+1)'(15);
    end_count = len_round[LenW:4];
  end

  assign red   = scale(widen5(pixel_value[15:11]), brightness);
  assign green = scale(widen6(pixel_value[10:5]), brightness);
  assign blue  = scale(widen5(pixel_value[4:0]), brightness);

  always_comb begin
    job.frame = '1;
    job.count = '0;
    unique case (action)
      ActBegin: begin
        job.frame = '0;
        job.count = CountW'(FrameBytes);
      end
      ActPixel: begin
        job.frame = {FillByte, blue, green, red};
        job.count = CountW'(FrameBytes);
      end
      ActEnd: begin
        // end frame is all fill bytes, capped at the per-command limit
        if ({1'b0, end_count} > (LenW-2)'(ResultLimit)) begin
          job.count = CountW'(ResultLimit);
        end else begin
          job.count = CountW'(end_count);
        end
      end
      default: begin
        job.count = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lsf_serializer.sv -----
// Job and output registers: sends one job byte per cycle unless out_ready stalls.
// Depends on lsf_pkg.
`default_nettype none

module lsf_serializer
  import lsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_take,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       last_byte
);

  logic [31:0]       shifter;
  logic [CountW-1:0] left;
  logic              out_free;
  logic              emit;
  logic              final_emit;

  assign out_free   = !out_valid || out_ready;
  assign emit       = busy && out_free;
  assign final_emit = emit && (left == CountW'(1));
  // a new job loads as soon as the last byte of the current one moves out
  assign job_take   = job_valid && (!busy || final_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_take) begin
      busy <= (job.count != '0);
    end else if (final_emit) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      shifter <= job.frame;
      left    <= job.count;
    end else if (emit) begin
      shifter <= {shifter[23:0], FillByte};
      left    <= left - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      data_byte <= shifter[31:24];
      last_byte <= (left == CountW'(1));
    end
  end

endmodule

`default_nettype wire

// ----- src/rgb565_led_strip_framer_top.sv -----
// Top level of the RGB565 LED strip framer: config registers, command register, serializer.
// Depends on lsf_pkg, lsf_encode and lsf_serializer.
//
// Usage:
//   in channel (in_valid/in_ready, action, pixel_value): one command per transfer.
//     begin sends four zero bytes, pixel sends 0xFF, blue, green, red scaled by
//     brightness, end sends ceil(strip_length/16) bytes of 0xFF (none when zero).
//     Unused action code 3 is dropped without output.
//   out channel (out_valid/out_ready, data_byte, last_byte): one byte per transfer,
//     last_byte marks the final byte of a command.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 brightness,
//     index 1 strip length; always ready, write only while the block is idle.
// Path: the first byte of a command passes the command, job and output registers.
// Throughput: one output byte per cycle while the receiver keeps out_ready high; the
//   serializer sets the rate. The next command is held in
//   the command register and loads in the cycle its predecessor's last byte
//   moves out, so byte streams of successive commands run back to back.
// Reset: brightness 64, strip length 0, all channels empty.
// A stalled receiver holds the output byte; the serializer and then the
//   command register fill, after which in_ready drops.
`default_nettype none

module rgb565_led_strip_framer_top
  import lsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] pixel_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [7:0]  brightness;
  logic [9:0]  strip_length;
  logic        in_full;
  logic [1:0]  cmd_action;
  logic [15:0] cmd_pixel;
  logic        job_take;
  logic        busy;
  logic        in_fire;
  job_t        job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= BrightnessReset;
      strip_length <= StripLengthReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgBrightness:  brightness <= cfg_data[7:0];
        CfgStripLength: strip_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !in_full || job_take;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_fire) begin
      in_full <= 1'b1;
    end else if (job_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_action <= action;
      cmd_pixel  <= pixel_value;
    end
  end

  lsf_encode u_encode (
    .action       (cmd_action),
    .pixel_value  (cmd_pixel),
    .brightness   (brightness),
    .strip_length (strip_length),
    .job          (job)
  );

  lsf_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .job_valid (in_full),
    .job       (job),
    .job_take  (job_take),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .last_byte (last_byte)
  );

  // a byte that is not the last of its command is always followed at once
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("byte stream gap inside a command");

  // a waiting command stays put until the serializer takes it
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !job_take |=> in_full && $stable(cmd_action) && $stable(cmd_pixel))
    else $error("pending command lost or changed");

  // a transferred command always lands in the command register
  a_cmd_capture: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> in_full && cmd_action == $past(action))
    else $error("command not captured");

  // output register only fills while the serializer has work
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    !busy && (!out_valid || out_ready) |=> !out_valid)
    else $error("output byte without an active job");

endmodule

`default_nettype wire

// ----- dv/rgb565_led_strip_framer_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the LED strip framer: watches the cfg, command and byte channels,
// predicts the byte stream per command and compares it. Depends on lsf_pkg.
module rgb565_led_strip_framer_checker
  import lsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] pixel_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          bytes_pending,
  output int          bytes_seen
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } led_byte_t;

  led_byte_t  expected_q[$];
  logic [7:0] brightness;
  logic [9:0] strip_len;

  // floor(c * level / 255)
  function automatic logic [7:0] dim(input logic [7:0] c, input logic [7:0] level);
    int unsigned prod;
    prod = c * level;
    return 8'(prod / 255);
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic last);
    led_byte_t b;
    b.data = data;
    b.last = last;
    expected_q.push_back(b);
  endtask

  task automatic push_frame(input logic [31:0] frame);
    for (int i = 0; i < FrameBytes; i++)
      push_byte(frame[31 - 8*i -: 8], i == FrameBytes - 1);
  endtask

  task automatic predict_command(input logic [1:0] act, input logic [15:0] pix);
    logic [7:0]  r8, g8, b8;
    int unsigned len, fill;
    case (act)
      ActBegin: push_frame(32'd0);
      ActPixel: begin
        // widen by replicating the top bits into the low bits
        b8 = {pix[4:0], pix[4:2]};
        g8 = {pix[10:5], pix[10:9]};
        r8 = {pix[15:11], pix[15:13]};
        push_frame({8'hFF, dim(b8, brightness), dim(g8, brightness), dim(r8, brightness)});
      end
      ActEnd: begin
        len = (strip_len > MaxLeds) ? MaxLeds : strip_len;
        fill = (len + 15) / 16;
        if (fill > ResultLimit) fill = ResultLimit;
        for (int i = 0; i < fill; i++)
          push_byte(FillByte, i == fill - 1);
      end
      default: ;  // unused code, nothing goes out
    endcase
  endtask

  always @(posedge clk) begin : monitor
    led_byte_t want;
    int        errs_now;
    errs_now = 0;
    if (rst) begin
      brightness = BrightnessReset;
      strip_len = StripLengthReset;
      expected_q.delete();
      fail_count <= 0;
      bytes_pending <= 0;
      bytes_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgBrightness) brightness = cfg_data[7:0];
        else strip_len = cfg_data;
      end
      if (in_valid && in_ready) predict_command(action, pixel_value);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("data_byte: expected none, got %02h", data_byte);
          errs_now++;
        end else begin
          want = expected_q.pop_front();
          if (data_byte !== want.data) begin
            $error("data_byte: expected %02h, got %02h", want.data, data_byte);
            errs_now++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte);
            errs_now++;
          end
        end
        bytes_seen <= bytes_seen + 1;
      end
      fail_count <= fail_count + errs_now;
      bytes_pending <= expected_q.size();
    end
  end

endmodule

// ----- dv/rgb565_led_strip_framer_top_test.sv -----
`timescale 1ns / 100ps
// LED strip framer testbench top: clock, reset, commands, registers, back-pressure.
// Depends on lsf_pkg, the framer RTL and rgb565_led_strip_framer_checker.
module rgb565_led_strip_framer_top_test;
  import lsf_pkg::*;

  localparam logic [1:0] ActUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ActBegin;
  logic [15:0] pixel_value = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index = CfgBrightness;
  logic [9:0]  cfg_data = 10'd0;

  int fail_count, bytes_pending, bytes_seen;
  int commands_sent = 0;
  int unused_sent = 0;
  int settings_used = 1;
  bit steady = 1'b0;

  always #10 clk = ~clk;

  rgb565_led_strip_framer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .pixel_value(pixel_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rgb565_led_strip_framer_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .bytes_pending(bytes_pending),
    .bytes_seen   (bytes_seen)
  );

  // receiver back-pressure in bursts
  initial begin
    @(posedge clk);
    forever begin
      if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  task automatic send_command(input logic [1:0] act, input logic [15:0] pix);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    pixel_value <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ActUnused) unused_sent++;
    else commands_sent++;
  endtask

  // wait for the last byte, then for a command that makes no bytes to settle
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // leaves cfg_valid high so writes can follow back to back
  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_levels(input logic [7:0] level, input logic [9:0] len);
    drain();
    write_reg(CfgBrightness, {2'b00, level});
    write_reg(CfgStripLength, len);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [9:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'($urandom_range(1, 17));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset levels: brightness 64, zero-length strip
    send_command(ActBegin, 16'hFFFF);
    send_command(ActPixel, 16'h0000);
    send_command(ActPixel, 16'hFFFF);
    send_command(ActPixel, 16'hF800);
    send_command(ActPixel, 16'h07E0);
    send_command(ActPixel, 16'h001F);
    send_command(ActPixel, 16'hAAAA);
    send_command(ActEnd, 16'h5555);
    send_command(ActUnused, 16'hFFFF);

    set_levels(8'd255, 10'd1023);
    send_command(ActBegin, 16'h0000);
    send_command(ActPixel, 16'hFFFF);
    send_command(ActPixel, 16'h8410);
    send_command(ActPixel, 16'h0821);
    send_command(ActEnd, 16'hFFFF);

    set_levels(8'd0, 10'd1);
    send_command(ActPixel, 16'hFFFF);
    send_command(ActEnd, 16'h0000);

    set_levels(8'd1, 10'd17);
    send_command(ActPixel, 16'hFFFF);
    send_command(ActEnd, 16'h0000);

    // random frames: begin, a run of pixels, mostly an end, stray commands now and then
    while (commands_sent < 110) begin
      set_levels(pick_byte(), pick_len());
      repeat ($urandom_range(1, 3)) begin
        send_command(ActBegin, 16'($urandom));
        repeat ($urandom_range(1, 6)) send_command(ActPixel, 16'($urandom));
        if ($urandom_range(0, 7) == 0)
          send_command(2'($urandom_range(0, 3)), 16'($urandom));
        if ($urandom_range(0, 9) != 0) send_command(ActEnd, 16'($urandom));
      end
      if (commands_sent > 90) steady = 1'b1;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d commands and %0d unused codes over %0d register settings",
             commands_sent, unused_sent, settings_used);
    $display("%0d output bytes compared", bytes_seen);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
